/* rtl/crr_pkg.sv */
package crr_pkg;

  // Fixed header length of a control-mode packet in bytes.
  localparam int unsigned HEADER_BYTES = 12;

  // Mode code of a control-mode packet.
  localparam logic [2:0] CTRL_MODE = 3'd6;

  // Largest payload count that fits the store count field.
  localparam int unsigned STORE_COUNT_MAX = 511;

  // Width of a fragment offset or end compared across the cell row.
  localparam int unsigned KEY_W = 17;

  // Width of the padded-length sum.
  localparam int unsigned PAD_W = 18;

  // Padding mask, error code mask and alignment mask.
  localparam logic [PAD_W-1:0] PAD_MASK = ~PAD_W'(3);
  localparam logic [7:0] ERROR_CODE_MASK = 8'hff;
  localparam logic [1:0] ALIGN_MASK = 2'h3;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_EXPECTED_OPCODE   = 2'd0,
    CFG_EXPECTED_SEQUENCE = 2'd1,
    CFG_MIN_VERSION       = 2'd2,
    CFG_MAX_VERSION       = 2'd3
  } cfg_index_t;

  // Item kinds.
  typedef enum logic {
    OP_PACKET  = 1'b0,
    OP_TIMEOUT = 1'b1
  } op_t;

  // Result codes.
  typedef enum logic [2:0] {
    OUT_PENDING      = 3'd0,
    OUT_IGNORED      = 3'd1,
    OUT_COMPLETE     = 3'd2,
    OUT_TIMEOUT_EMPTY = 3'd3,
    OUT_INCOMPLETE   = 3'd4,
    OUT_TOO_MUCH     = 3'd5,
    OUT_REMOTE_ERROR = 3'd6,
    OUT_UNSPEC_ERROR = 3'd7
  } outcome_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_DECIDE
  } state_t;

  // One input item.
  typedef struct packed {
    logic        op;
    logic [9:0]  pkt_len;
    logic [7:0]  ver_mode;
    logic [7:0]  resp_flags;
    logic [15:0] seq_number;
    logic [15:0] pkt_status;
    logic [15:0] frag_offset;
    logic [15:0] frag_count;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [2:0]  outcome;
    logic [13:0] store_offset;
    logic [8:0]  store_count;
    logic [14:0] response_size;
    logic [15:0] response_status;
    logic [7:0]  remote_error;
  } out_item_t;

  // Broadcast from the sequencer to every cell of the fragment row.
  typedef struct packed {
    logic             cmp_en;
    logic             ins_en;
    logic [KEY_W-1:0] key_off;
    logic [KEY_W-1:0] key_lim;
    logic [8:0]       key_cnt;
  } cell_bus_t;

endpackage

/* rtl/crr_cell.sv */
module crr_cell #(
  parameter int unsigned OFF_W = 15
) (
  input  logic               clk,
  input  logic               valid,
  input  crr_pkg::cell_bus_t ctl,
  input  logic               prev_lt,
  input  logic [OFF_W-1:0]   prev_off,
  input  logic [8:0]         prev_cnt,
  output logic [OFF_W-1:0]   off,
  output logic [8:0]         cnt,
  output logic               lt,
  output logic               hit
);

  localparam int unsigned KeyW = crr_pkg::KEY_W;

  logic [KeyW-1:0] off_w;
  logic [KeyW-1:0] lim_w;
  logic            lt_now;
  logic            hit_now;

  // Compare the held fragment with the broadcast one.
  always_comb begin
    off_w   = KeyW'(off);
    lim_w   = off_w + KeyW'(cnt);
    lt_now  = valid && (off_w < ctl.key_off);
    hit_now = valid && ((off_w == ctl.key_off) ||
                        (lt_now && (lim_w > ctl.key_off)) ||
                        (!lt_now && (ctl.key_lim > off_w)));
  end

  // Keep the compare flags for the decision cycle.
  always_ff @(posedge clk) begin
    if (ctl.cmp_en) begin
      lt  <= lt_now;
      hit <= hit_now;
    end
  end

  // On insertion a cell past the insert point takes its left neighbor's entry,
  // and the cell at the insert point takes the new fragment.
  always_ff @(posedge clk) begin
    if (ctl.ins_en && !lt) begin
      if (prev_lt) begin
        off <= ctl.key_off[OFF_W-1:0];
        cnt <= ctl.key_cnt;
      end else begin
        off <= prev_off;
        cnt <= prev_cnt;
      end
    end
  end

endmodule

/* rtl/control_response_reassembler_unit.sv */
// Reassembles a fragmented control-mode response from packet headers and
// timeout ticks, giving exactly one result item per input item. Each item
// goes through capture, a parallel compare of the new fragment against every
// row entry, and the decision that loads the result register and shifts the
// row to insert the fragment. The decision waits while the result register
// still holds an untaken item, and the next item is accepted once the
// decision is made. The fragment row holds MAX_FRAGMENTS entries, kept
// sorted by offset; completion is detected by comparing the running byte
// total with the furthest fragment end. No clearing pass follows reset.
// Configuration must be written only while idle (not enforced).
module control_response_reassembler_unit #(
  parameter int unsigned MAX_FRAGMENTS = 32,
  parameter int unsigned BUFFER_BYTES  = 16384
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  crr_pkg::in_item_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output crr_pkg::out_item_t out_data,
  input  logic              cfg_write,
  input  logic [1:0]        cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int unsigned AW   = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned TW   = $clog2(MAX_FRAGMENTS + 1);
  localparam int unsigned KeyW = crr_pkg::KEY_W;
  localparam int unsigned PadW = crr_pkg::PAD_W;

  // Configuration registers.
  logic [4:0]  expected_opcode;
  logic [15:0] expected_sequence;
  logic [2:0]  min_version;
  logic [2:0]  max_version;

  // Exchange state.
  logic [TW-1:0] total;
  logic          last_seen;
  logic [15:0]   saved_status;
  logic [AW-1:0] byte_sum;
  logic [AW-1:0] max_end;

  crr_pkg::state_t   state;
  crr_pkg::state_t   state_next;
  crr_pkg::in_item_t item;
  crr_pkg::out_item_t res;
  crr_pkg::cell_bus_t bus;

  logic accept;
  logic cmp_en;
  logic commit;
  logic insert;
  logic terminal;
  logic complete;

  // Cell row wiring.
  logic [MAX_FRAGMENTS-1:0] cell_valid;
  logic [MAX_FRAGMENTS-1:0] cell_lt;
  logic [MAX_FRAGMENTS-1:0] cell_hit;
  logic [MAX_FRAGMENTS-1:0] chain_lt;
  logic [AW-1:0]            cell_off [MAX_FRAGMENTS];
  logic [8:0]               cell_cnt [MAX_FRAGMENTS];
  logic [AW-1:0]            chain_off [MAX_FRAGMENTS];
  logic [8:0]               chain_cnt [MAX_FRAGMENTS];

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_opcode   <= '0;
      expected_sequence <= '0;
      min_version       <= 3'd1;
      max_version       <= 3'd4;
    end else if (cfg_write) begin
      case (crr_pkg::cfg_index_t'(cfg_index))
        crr_pkg::CFG_EXPECTED_OPCODE:   expected_opcode   <= cfg_data[4:0];
        crr_pkg::CFG_EXPECTED_SEQUENCE: expected_sequence <= cfg_data;
        crr_pkg::CFG_MIN_VERSION:       min_version       <= cfg_data[2:0];
        crr_pkg::CFG_MAX_VERSION:       max_version       <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= crr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      crr_pkg::ST_IDLE: begin
        if (in_valid) state_next = crr_pkg::ST_COMPARE;
      end
      crr_pkg::ST_COMPARE: begin
        state_next = crr_pkg::ST_DECIDE;
      end
      crr_pkg::ST_DECIDE: begin
        if (!out_valid || out_ready) state_next = crr_pkg::ST_IDLE;
      end
      default: state_next = crr_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready = 1'b0;
    cmp_en   = 1'b0;
    commit   = 1'b0;
    case (state)
      crr_pkg::ST_IDLE:    in_ready = 1'b1;
      crr_pkg::ST_COMPARE: cmp_en   = 1'b1;
      crr_pkg::ST_DECIDE:  commit   = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // Item capture.
  always_ff @(posedge clk) begin
    if (accept) item <= in_data;
  end

  // Broadcast of the fragment under test to the cell row.
  always_comb begin
    bus.cmp_en  = cmp_en;
    bus.ins_en  = commit && insert;
    bus.key_off = KeyW'(item.frag_offset);
    bus.key_lim = KeyW'(item.frag_offset) + KeyW'(item.frag_count);
    bus.key_cnt = item.frag_count[8:0];
  end

  // Row of fragment cells, each handing its entry to its right neighbor.
  for (genvar i = 0; i < MAX_FRAGMENTS; i++) begin : g_cell
    assign cell_valid[i] = total > TW'(i);
    if (i == 0) begin : g_head
      assign chain_lt[i]  = 1'b1;
      assign chain_off[i] = '0;
      assign chain_cnt[i] = '0;
    end else begin : g_body
      assign chain_lt[i]  = cell_lt[i-1];
      assign chain_off[i] = cell_off[i-1];
      assign chain_cnt[i] = cell_cnt[i-1];
    end
    crr_cell #(
      .OFF_W(AW)
    ) u_cell (
      .clk      (clk),
      .valid    (cell_valid[i]),
      .ctl      (bus),
      .prev_lt  (chain_lt[i]),
      .prev_off (chain_off[i]),
      .prev_cnt (chain_cnt[i]),
      .off      (cell_off[i]),
      .cnt      (cell_cnt[i]),
      .lt       (cell_lt[i]),
      .hit      (cell_hit[i])
    );
  end

  // Header fields and derived values.
  logic [2:0]      version;
  logic            more;
  logic            hdr_bad;
  logic [PadW-1:0] padded;
  logic [9:0]      body_len;
  logic [AW-1:0]   sum_next;
  logic [AW-1:0]   lim_a;
  logic [AW-1:0]   end_next;
  logic [KeyW-1:0] size_w;

  always_comb begin
    version  = item.ver_mode[5:3];
    more     = item.resp_flags[5];
    hdr_bad  = (item.pkt_len < 10'(crr_pkg::HEADER_BYTES)) ||
               (version > max_version) || (version < min_version) ||
               (item.ver_mode[2:0] != crr_pkg::CTRL_MODE) ||
               !item.resp_flags[7] ||
               (item.seq_number != expected_sequence) ||
               (item.resp_flags[4:0] != expected_opcode);
    padded   = (PadW'(crr_pkg::HEADER_BYTES) + PadW'(item.frag_count) + PadW'(3)) &
               crr_pkg::PAD_MASK;
    body_len = item.pkt_len - 10'(crr_pkg::HEADER_BYTES);
    sum_next = byte_sum + AW'(item.frag_count[8:0]);
    lim_a    = bus.key_lim[AW-1:0];
    end_next = (lim_a > max_end) ? lim_a : max_end;
    complete = (last_seen || !more) && (sum_next == end_next);
    size_w   = KeyW'(end_next);
  end

  // Decision on the captured item.
  always_comb begin
    res                 = '0;
    res.response_status = saved_status;
    insert              = 1'b0;
    if (item.op == crr_pkg::OP_TIMEOUT) begin
      res.outcome = (total == '0) ? crr_pkg::OUT_TIMEOUT_EMPTY : crr_pkg::OUT_INCOMPLETE;
    end else if (hdr_bad) begin
      res.outcome = crr_pkg::OUT_IGNORED;
    end else if (item.resp_flags[6]) begin
      if ((item.pkt_status[15:8] & crr_pkg::ERROR_CODE_MASK) == 8'd0) begin
        res.outcome = crr_pkg::OUT_UNSPEC_ERROR;
      end else begin
        res.outcome      = crr_pkg::OUT_REMOTE_ERROR;
        res.remote_error = item.pkt_status[15:8];
      end
    end else if ((item.pkt_len[1:0] & crr_pkg::ALIGN_MASK) != 2'd0) begin
      res.outcome = crr_pkg::OUT_IGNORED;
    end else if (PadW'(item.pkt_len) < padded) begin
      res.outcome = crr_pkg::OUT_INCOMPLETE;
    end else if (item.frag_count > 16'(body_len)) begin
      res.outcome = crr_pkg::OUT_IGNORED;
    end else if ((item.frag_count == 16'd0) && more) begin
      res.outcome = crr_pkg::OUT_IGNORED;
    end else if ((bus.key_lim > KeyW'(BUFFER_BYTES)) ||
                 (item.frag_count > 16'(crr_pkg::STORE_COUNT_MAX))) begin
      res.outcome = crr_pkg::OUT_TOO_MUCH;
    end else if (last_seen && !more) begin
      res.outcome = crr_pkg::OUT_IGNORED;
    end else if (total >= TW'(MAX_FRAGMENTS)) begin
      res.outcome = crr_pkg::OUT_TOO_MUCH;
    end else if (|cell_hit) begin
      res.outcome = crr_pkg::OUT_IGNORED;
    end else begin
      insert           = 1'b1;
      res.outcome      = complete ? crr_pkg::OUT_COMPLETE : crr_pkg::OUT_PENDING;
      res.store_offset = item.frag_offset[13:0];
      res.store_count  = item.frag_count[8:0];
      res.response_size = complete ? size_w[14:0] : 15'd0;
      if (!more) res.response_status = item.pkt_status;
    end
    terminal = !((res.outcome == crr_pkg::OUT_PENDING) ||
                 (res.outcome == crr_pkg::OUT_IGNORED));
  end

  // Exchange state update; a terminal outcome clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      total        <= '0;
      last_seen    <= 1'b0;
      saved_status <= '0;
      byte_sum     <= '0;
      max_end      <= '0;
    end else if (commit) begin
      if (terminal) begin
        total        <= '0;
        last_seen    <= 1'b0;
        saved_status <= '0;
        byte_sum     <= '0;
        max_end      <= '0;
      end else if (insert) begin
        total    <= total + TW'(1);
        byte_sum <= sum_next;
        max_end  <= end_next;
        if (!more) begin
          last_seen    <= 1'b1;
          saved_status <= item.pkt_status;
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) out_data <= res;
  end

  // The row never holds more fragments than it has cells.
  a_total_bound: assert property (@(posedge clk) disable iff (rst)
    total <= TW'(MAX_FRAGMENTS))
    else $error("fragment count beyond row size");

  // A last fragment is only recorded together with at least one entry.
  a_last_has_entry: assert property (@(posedge clk) disable iff (rst)
    last_seen |-> (total != '0))
    else $error("last fragment flag without entries");

  // A terminal result leaves an empty exchange behind.
  a_terminal_clears: assert property (@(posedge clk) disable iff (rst)
    (commit && terminal) |=> ((total == '0) && !last_seen && (saved_status == '0)))
    else $error("exchange not cleared after terminal result");

  // An insertion grows the row by exactly one entry.
  a_insert_grows: assert property (@(posedge clk) disable iff (rst)
    (commit && insert && !terminal) |=> (total == $past(total) + TW'(1)))
    else $error("insertion did not grow the row by one");

  // The decision is only taken when the result register can take it.
  a_commit_room: assert property (@(posedge clk) disable iff (rst)
    commit |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

endmodule
